FILE: src/bloom_filter_fnv_double_hash_core_assert.svh
// Assertion macros for the bloom filter core.
`ifndef BLOOM_FILTER_FNV_DOUBLE_HASH_CORE_ASSERT_SVH
`define BLOOM_FILTER_FNV_DOUBLE_HASH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BFD_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("bloom filter check failed");
`define BFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bloom filter sequence check failed");
`else
`define BFD_ASSERT_NEVER(lbl, expr)
`define BFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/bfd_pkg.sv
package bfd_pkg;
   localparam int unsigned BIT_CAPACITY = 65536;
   localparam int unsigned ADDR_W = $clog2(BIT_CAPACITY);
   localparam int unsigned MAX_PROBES = 32;
   localparam int unsigned PROBE_W = $clog2(MAX_PROBES);
   localparam int unsigned NBITS_W = 17;
   localparam int unsigned NHASH_W = 6;
   localparam int unsigned CAP_W = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REM_W = NBITS_W;
   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [NBITS_W-1:0] NBITS_MIN = NBITS_W'(8);
   localparam logic [NBITS_W-1:0] NBITS_MAX = NBITS_W'(BIT_CAPACITY);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_BITS = 2'd0,
      CSR_NUM_HASHES = 2'd1,
      CSR_CAPACITY = 2'd2
   } csr_idx_type;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] key_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        saturated;
      logic [31:0] add_total;
   } rsp_type;

   typedef struct packed {
      logic        cmd;
      logic [63:0] hash;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // xor in the byte, then multiply by the FNV prime 2^40 + 0x1B3, modulo 2^64
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
   endfunction
endpackage

FILE: src/bfd_front.sv
module bfd_front
   import bfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         hold,
   input  q_status_type q_status,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         push,
   output job_type      push_job
);
   logic [63:0] hash_ff, hash_in, hash_next;
   logic        accept;

   assign req_ready = !hold && !q_status.full;
   assign accept = req_valid && req_ready;
   assign hash_next = fnv_step(hash_ff, req_data.key_byte);
   assign push = accept && req_data.last;
   assign push_job = '{cmd: req_data.cmd, hash: hash_next};

   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         hash_in = req_data.last ? FNV_BASIS : hash_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end
endmodule

FILE: src/bfd_fifo.sv
module bfd_fifo
   import bfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head_job,
   output q_status_type q_status
);
   job_type     entries_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign head_job = entries_ff[rd_ptr_ff];
   assign q_status = '{full: count_ff == 2'd2, empty: count_ff == 2'd0};

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end
endmodule

FILE: src/bfd_mod.sv
module bfd_mod
   import bfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        num,
   input  logic [NBITS_W-1:0] den,
   output logic               done,
   output logic [REM_W-1:0]   rem
);
   logic [31:0]      num_ff, num_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W:0]   shifted;

   assign shifted = {rem_ff, num_ff[31]};
   assign done = done_ff;
   assign rem = rem_ff;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = num;
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[30:0], 1'b0};
         if (shifted >= {1'b0, den}) begin
            rem_in = REM_W'(shifted - {1'b0, den});
         end else begin
            rem_in = REM_W'(shifted);
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

FILE: src/bfd_back.sv
module bfd_back
   import bfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [NBITS_W-1:0] m_eff,
   input  logic [PROBE_W-1:0] k_last,
   input  logic [CAP_W-1:0]   capacity,
   input  q_status_type       q_status,
   input  job_type            head_job,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);
   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_MOD, ST_PROBE, ST_DRAIN, ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic               cmd_ff;
   logic [63:0]        hash_ff;
   logic               mod_start_ff;
   logic [NBITS_W-1:0] pos_ff, step_ff;
   logic [PROBE_W-1:0] j_ff;
   logic               all_set_ff;
   logic               chk_vld_ff;
   logic               rd_ff;
   logic [31:0]        count_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               bits_ff [BIT_CAPACITY];

   logic               h1_done, h2_done;
   logic [REM_W-1:0]   h1_rem, h2_rem;
   logic [NBITS_W:0]   pos_sum;
   logic [NBITS_W-1:0] pos_in;
   logic               all_set_in;
   logic [31:0]        count_in;
   logic               mem_we, mem_wd;
   logic [ADDR_W-1:0]  mem_wa;
   logic               out_free;

   bfd_mod u_mod_h1 (
      .clock(clock), .reset(reset), .start(mod_start_ff), .num(hash_ff[31:0]),
      .den(m_eff), .done(h1_done), .rem(h1_rem)
   );

   bfd_mod u_mod_h2 (
      .clock(clock), .reset(reset), .start(mod_start_ff),
      .num(hash_ff[63:32] | 32'd1), .den(m_eff), .done(h2_done), .rem(h2_rem)
   );

   assign clearing = (state_ff == ST_CLEAR);
   assign pop = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign pos_sum = {1'b0, pos_ff} + {1'b0, step_ff};
   assign pos_in = (pos_sum >= {1'b0, m_eff}) ? NBITS_W'(pos_sum - {1'b0, m_eff})
                                              : NBITS_W'(pos_sum);
   assign all_set_in = all_set_ff && !(chk_vld_ff && !rd_ff);
   assign count_in = (cmd_ff == CMD_ADD && count_ff != 32'hFFFFFFFF) ? count_ff + 32'd1
                                                                   : count_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wd = 1'b0;
      mem_wa = pos_ff[ADDR_W-1:0];
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
      end else if (state_ff == ST_PROBE && cmd_ff == CMD_ADD) begin
         mem_we = 1'b1;
         mem_wd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bits_ff[mem_wa] <= mem_wd;
      end
      rd_ff <= bits_ff[pos_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         mod_start_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
         all_set_ff <= 1'b1;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mod_start_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
         all_set_ff <= all_set_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == ADDR_W'(BIT_CAPACITY - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (!q_status.empty) begin
                  cmd_ff <= head_job.cmd;
                  hash_ff <= head_job.hash;
                  mod_start_ff <= 1'b1;
                  state_ff <= ST_MOD;
               end
            end
            ST_MOD: begin
               if (h1_done && h2_done) begin
                  pos_ff <= h1_rem;
                  step_ff <= h2_rem;
                  j_ff <= '0;
                  all_set_ff <= 1'b1;
                  state_ff <= ST_PROBE;
               end
            end
            ST_PROBE: begin
               chk_vld_ff <= (cmd_ff == CMD_QUERY);
               pos_ff <= pos_in;
               j_ff <= j_ff + 1'b1;
               if (j_ff == k_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  count_ff <= count_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.hit <= (cmd_ff == CMD_QUERY) && all_set_ff;
                  rsp_ff.saturated <= (capacity != '0) && (count_in > capacity);
                  rsp_ff.add_total <= count_in;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule

FILE: src/bloom_filter_fnv_double_hash_core.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_data (cmd, key_byte, last)
// rsp     | out       | rsp_valid/rsp_ready  | rsp_data (hit, saturated, add_total)
// csr     | in        | csr_we               | csr_addr, csr_wdata
// Key bytes hash at one per cycle while req_ready is high; a two-entry
// queue holds finished keys. The back end then runs each key through the
// bit-serial modulo units (h1, h2 in parallel), one bit store access per probe.
// After reset all 65536 bit store entries are cleared; req_ready stays low.
// req_ready drops while the queue is full; rsp holds in its output register.
`include "bloom_filter_fnv_double_hash_core_assert.svh"
module bloom_filter_fnv_double_hash_core
   import bfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [CAP_W-1:0]     csr_wdata
);
   logic [NBITS_W-1:0] num_bits_ff;
   logic [NHASH_W-1:0] num_hashes_ff;
   logic [CAP_W-1:0]   capacity_ff;
   logic [NBITS_W-1:0] m_eff;
   logic [NHASH_W-1:0] k_eff;
   logic [PROBE_W-1:0] k_last;
   logic               clearing, push, pop;
   job_type            push_job, head_job;
   q_status_type       q_status;

   always_comb begin
      m_eff = num_bits_ff;
      if (num_bits_ff < NBITS_MIN) m_eff = NBITS_MIN;
      if (num_bits_ff > NBITS_MAX) m_eff = NBITS_MAX;
      k_eff = num_hashes_ff;
      if (num_hashes_ff == '0) k_eff = NHASH_W'(1);
      if (num_hashes_ff > NHASH_W'(MAX_PROBES)) k_eff = NHASH_W'(MAX_PROBES);
   end
   assign k_last = PROBE_W'(k_eff - NHASH_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bits_ff <= NBITS_W'(65536);
         num_hashes_ff <= NHASH_W'(7);
         capacity_ff <= CAP_W'(4096);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_NUM_BITS: num_bits_ff <= csr_wdata[NBITS_W-1:0];
            CSR_NUM_HASHES: num_hashes_ff <= csr_wdata[NHASH_W-1:0];
            CSR_CAPACITY: capacity_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bfd_front u_front (
      .clock(clock), .reset(reset), .hold(clearing), .q_status(q_status),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .push(push), .push_job(push_job)
   );

   bfd_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job), .pop(pop),
      .head_job(head_job), .q_status(q_status)
   );

   bfd_back u_back (
      .clock(clock), .reset(reset), .m_eff(m_eff), .k_last(k_last),
      .capacity(capacity_ff), .q_status(q_status), .head_job(head_job), .pop(pop),
      .clearing(clearing), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   `BFD_ASSERT_NEVER(a_no_req_in_clear, req_valid && req_ready && clearing)
   `BFD_ASSERT_NEVER(a_q_full_empty, q_status.full && q_status.empty)
   `BFD_ASSERT_NEVER(a_sat_count, rsp_valid && rsp_data.saturated && rsp_data.add_total == '0)
   `BFD_ASSERT_NEXT(a_push_not_empty, push && !pop, !q_status.empty)
endmodule

FILE: tb/sv/tb_bloom_filter_fnv_double_hash_core.sv
`timescale 1ns / 100ps
module tb_bloom_filter_fnv_double_hash_core;
   import bfd_pkg::*;

   localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 150000;
   localparam int POOL_SIZE = 64;
   localparam int KEY_MAX = 8;
   localparam int HOLD_CYCLES = 3000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_addr;
   logic [CAP_W-1:0]     csr_wdata;

   bloom_filter_fnv_double_hash_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // filter state mirror
   logic [63:0]          fnv_acc;
   logic                 filter_bits [BIT_CAPACITY];
   logic [31:0]          added_keys;
   logic [NBITS_W-1:0]   cfg_num_bits;
   logic [NHASH_W-1:0]   cfg_num_hashes;
   logic [CAP_W-1:0]     cfg_capacity;

   rsp_type              expected_rsp_q [$];
   int                   error_count;
   int                   bytes_sent;
   int                   idle_cycles = 0;
   int                   rsp_hold_off = 0;
   int                   hold_requests;
   int                   holds_taken = 0;
   bit                   sender_steady;
   bit                   receiver_steady;

   logic [7:0]           key_pool [POOL_SIZE][KEY_MAX];
   int                   key_len [POOL_SIZE];

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
      error_count++;
   endtask

   function automatic void bloom_accept_byte(input req_type item);
      logic [31:0] h1;
      logic [31:0] h2;
      logic [63:0] m;
      logic [63:0] k;
      logic [63:0] pos;
      logic        all_set;
      rsp_type     r;
      fnv_acc = (fnv_acc ^ {56'd0, item.key_byte}) * FNV_PRIME;
      if (!item.last) return;
      h1 = fnv_acc[31:0];
      h2 = fnv_acc[63:32] | 32'd1;
      fnv_acc = FNV_BASIS;
      m = cfg_num_bits;
      if (m < 8) m = 8;
      if (m > BIT_CAPACITY) m = BIT_CAPACITY;
      k = cfg_num_hashes;
      if (k < 1) k = 1;
      if (k > MAX_PROBES) k = MAX_PROBES;
      all_set = 1'b1;
      for (logic [63:0] j = 0; j < k; j++) begin
         pos = ({32'd0, h1} + j * {32'd0, h2}) % m;
         if (item.cmd == CMD_ADD) begin
            filter_bits[pos] = 1'b1;
         end else if (!filter_bits[pos]) begin
            all_set = 1'b0;
         end
      end
      if (item.cmd == CMD_ADD && added_keys != 32'hFFFFFFFF) added_keys++;
      r.hit = (item.cmd == CMD_QUERY) && all_set;
      r.saturated = (cfg_capacity != 0) && (added_keys > cfg_capacity);
      r.add_total = added_keys;
      expected_rsp_q.push_back(r);
   endfunction

   // caller stands at a falling edge; returns at a falling edge
   task automatic send_byte(input logic cmd, input logic [7:0] b, input logic last);
      req_type item;
      int gap;
      item.cmd = cmd;
      item.key_byte = b;
      item.last = last;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      bloom_accept_byte(item);
      bytes_sent++;
      @(negedge clock);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_key(input logic cmd, input int idx);
      for (int i = 0; i < key_len[idx]; i++) begin
         send_byte(i == key_len[idx] - 1 ? cmd : logic'($urandom_range(0, 1)),
                   key_pool[idx][i], i == key_len[idx] - 1);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NUM_BITS) cfg_num_bits = val[NBITS_W-1:0];
      else if (idx == CSR_NUM_HASHES) cfg_num_hashes = val[NHASH_W-1:0];
      else if (idx == CSR_CAPACITY) cfg_capacity = val;
   endtask

   task automatic set_filter(input logic [CAP_W-1:0] nb, input logic [CAP_W-1:0] nh,
                             input logic [CAP_W-1:0] cap);
      drain();
      write_reg(CSR_NUM_BITS, nb);
      write_reg(CSR_NUM_HASHES, nh);
      write_reg(CSR_CAPACITY, cap);
   endtask

   task automatic random_traffic(input int nbytes);
      int target;
      int idx;
      target = bytes_sent + nbytes;
      while (bytes_sent < target) begin
         idx = $urandom_range(0, POOL_SIZE - 1);
         if ($urandom_range(0, 3) == 0) begin
            key_len[idx] = $urandom_range(0, 9) == 0 ? $urandom_range(5, KEY_MAX)
                                                    : $urandom_range(1, 4);
            for (int i = 0; i < KEY_MAX; i++) key_pool[idx][i] = 8'($urandom_range(0, 255));
         end
         send_key(logic'($urandom_range(0, 1)), idx);
      end
   endtask

   task automatic test_directed();
      key_len[0] = 1; key_pool[0][0] = 8'h00;
      key_len[1] = 1; key_pool[1][0] = 8'hFF;
      key_len[2] = KEY_MAX;
      for (int i = 0; i < KEY_MAX; i++) key_pool[2][i] = (i % 2) ? 8'hFF : 8'h00;
      send_key(CMD_QUERY, 0);
      send_key(CMD_ADD, 0);
      send_key(CMD_QUERY, 0);
      send_key(CMD_QUERY, 1);
      send_key(CMD_ADD, 1);
      send_key(CMD_QUERY, 1);
      send_key(CMD_ADD, 2);
      send_key(CMD_QUERY, 2);
   endtask

   task automatic test_config_extremes();
      set_filter(8, 1, 1);
      random_traffic(150);
      set_filter(BIT_CAPACITY, MAX_PROBES, 32'hFFFFFFFF);
      random_traffic(150);
      set_filter(32'h1FFFF, 32'h3F, 0);
      random_traffic(150);
      set_filter(0, 0, 5);
      write_reg(CSR_UNUSED, 32'hFFFFFFFF);
      random_traffic(150);
      set_filter(37, 3, 20);
      receiver_steady = 1'b1;
      sender_steady = 1'b1;
      random_traffic(150);
      receiver_steady = 1'b0;
      sender_steady = 1'b0;
   endtask

   task automatic test_backpressure();
      set_filter(1024, 32, 300);
      hold_requests++;
      sender_steady = 1'b1;
      random_traffic(200);
      sender_steady = 1'b0;
   endtask

   task automatic test_random();
      set_filter($urandom_range(8, 4096), $urandom_range(1, 32), $urandom_range(1, 500));
      random_traffic(300);
      set_filter($urandom_range(0, 131071), $urandom_range(0, 63), $urandom);
      random_traffic(300);
   endtask

   always @(negedge clock) begin
      if (hold_requests != holds_taken) begin
         holds_taken <= hold_requests;
         rsp_ready <= 1'b0;
         rsp_hold_off <= HOLD_CYCLES;
      end else if (rsp_hold_off > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_off <= rsp_hold_off - 1;
      end else if (receiver_steady) begin
         rsp_ready <= 1'b1;
      end else if (idle_cycles > 0) begin
         rsp_ready <= 1'b0;
         idle_cycles <= idle_cycles - 1;
      end else begin
         rsp_ready <= 1'b1;
         idle_cycles <= pick_gap();
      end
   end

   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data.add_total, 32'd0);
         end else begin
            exp = expected_rsp_q.pop_front();
            if (rsp_data.hit !== exp.hit)
               report_mismatch("hit", {31'd0, rsp_data.hit}, {31'd0, exp.hit});
            if (rsp_data.saturated !== exp.saturated)
               report_mismatch("saturated", {31'd0, rsp_data.saturated},
                               {31'd0, exp.saturated});
            if (rsp_data.add_total !== exp.add_total)
               report_mismatch("add_total", rsp_data.add_total, exp.add_total);
         end
      end
   end

   int stall_count = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("FAIL bloom_filter_fnv_double_hash_core");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      error_count = 0;
      bytes_sent = 0;
      hold_requests = 0;
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      fnv_acc = FNV_BASIS;
      added_keys = 0;
      cfg_num_bits = NBITS_W'(65536);
      cfg_num_hashes = NHASH_W'(7);
      cfg_capacity = 32'd4096;
      for (int i = 0; i < BIT_CAPACITY; i++) filter_bits[i] = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_len[i] = $urandom_range(1, 4);
         for (int b = 0; b < KEY_MAX; b++) key_pool[i][b] = 8'($urandom_range(0, 255));
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random();
      drain();
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("PASS bloom_filter_fnv_double_hash_core");
      end else begin
         $display("FAIL bloom_filter_fnv_double_hash_core");
      end
      $finish;
   end
endmodule
